FILE: sv/pfr_pkg.sv
// Shared constants, codes and types of the packet frame reassembler.
`default_nettype none

package pfr_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 7;
    localparam int OFFSET_W      = 16;
    localparam int FRAME_WORDS_W = 17;
    localparam int LAST_WORDS_W  = 7;
    localparam int PROD_W        = 24;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [POS_W-1:0] POS_FRAME       = 7'd3;
    localparam logic [POS_W-1:0] POS_PACKET      = 7'd4;
    localparam logic [POS_W-1:0] POS_FLAGS       = 7'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD     = 7'd7;
    localparam logic [POS_W-1:0] POS_PAYLOAD_END = 7'd126;

    localparam logic [LAST_WORDS_W-1:0] PAYLOAD_WORDS = 7'd120;

    localparam logic [DATA_W-1:0] END_MARK = 32'h0001_0001;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WORDS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_WORDS  = 1'd1;

    localparam logic [FRAME_WORDS_W-1:0] FRAME_WORDS_RST = 17'd120;
    localparam logic [LAST_WORDS_W-1:0]  LAST_WORDS_RST  = 7'd120;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_FRAME_ERR = 3'd1,
        KIND_SEQ_ERR   = 3'd2,
        KIND_SIZE_ERR  = 3'd3,
        KIND_LOST      = 3'd4,
        KIND_END       = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        COPY_NONE = 2'd0,
        COPY_FULL = 2'd1,
        COPY_LAST = 2'd2
    } copy_t;

    typedef struct packed {
        logic              emit;
        kind_t             kind;
        logic              stop;
        copy_t             copy;
        logic [DATA_W-1:0] cur_frame;
        logic [DATA_W-1:0] exp_packet;
        logic              frame_ok;
        logic              seq_ok;
        logic              skip;
    } hdr_dec_t;

endpackage

`default_nettype wire

FILE: sv/pfr_in_if.sv
// Input stream channel: one received word per handshake.
`default_nettype none

interface pfr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        batch_first;

    modport source (output valid, output data_word, output batch_first, input ready);
    modport sink   (input valid, input data_word, input batch_first, output ready);
endinterface

`default_nettype wire

FILE: sv/pfr_out_if.sv
// Result channel: payload words and status codes.
`default_nettype none

interface pfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] frame_offset;
    logic [31:0] payload;
    logic        frame_last;
    logic [31:0] frame_number;

    modport source (output valid, output kind, output frame_offset, output payload,
                    output frame_last, output frame_number, input ready);
    modport sink   (input valid, input kind, input frame_offset, input payload,
                    input frame_last, input frame_number, output ready);
endinterface

`default_nettype wire

FILE: sv/packet_frame_reassembler_top.sv
// Packet frame reassembler: header tracking, sequence and size checks, payload emission.
//
//   channel   dir  handshake           word contents
//   stream    in   valid/ready         data_word, batch_first
//   result    out  valid/ready         kind, frame_offset, payload, frame_last, frame_number
//   cfg       in   cfg_we              cfg_index, cfg_data
//
// One word per cycle while the result register is free or being taken; each word is decided
// by the logic between the state registers and the result register, so its result shows in the cycle after it is taken.
// The result register frees itself when taken, so stream.ready = !result.valid || result.ready.
// Reset returns all control state to its start values and loads 120 into both size registers.
// After an end marker no further words produce results until reset.
`default_nettype none

module packet_frame_reassembler_top
    import pfr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [FRAME_WORDS_W-1:0] cfg_data,
    pfr_in_if.sink                        stream,
    pfr_out_if.source                     result
);

    logic [FRAME_WORDS_W-1:0] frame_words_reg;
    logic [LAST_WORDS_W-1:0]  last_words_reg;

    logic [POS_W-1:0]    word_pos_reg,   word_pos_next;
    logic [DATA_W-1:0]   cur_frame_reg,  cur_frame_next;
    logic [DATA_W-1:0]   exp_packet_reg, exp_packet_next;
    logic                frame_ok_reg,   frame_ok_next;
    logic                seq_ok_reg,     seq_ok_next;
    logic                skip_reg,       skip_next;
    logic                stopped_reg,    stopped_next;
    copy_t               copy_reg,       copy_next;
    logic [DATA_W-1:0]   hdr_frame_reg,  hdr_frame_next;
    logic [DATA_W-1:0]   hdr_packet_reg, hdr_packet_next;
    logic                pkt_big_reg,    pkt_big_next;
    logic [PROD_W-1:0]   pkt_prod_reg,   pkt_prod_next;
    logic [OFFSET_W-1:0] base_reg,       base_next;

    logic                out_valid_reg,  out_valid_next;
    kind_t               kind_reg,       kind_next;
    logic [OFFSET_W-1:0] offset_reg,     offset_next;
    logic [DATA_W-1:0]   payload_reg,    payload_next;
    logic                last_reg,       last_next;
    logic [DATA_W-1:0]   fnum_reg,       fnum_next;

    logic                    accept;
    logic [POS_W-1:0]        pos;
    logic                    skip_eff;
    copy_t                   copy_eff;
    logic [POS_W-1:0]        idx;
    logic [LAST_WORDS_W-1:0] last_cnt;
    hdr_dec_t                dec;

    assign stream.ready        = !out_valid_reg || result.ready;
    assign accept              = stream.valid && stream.ready;
    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.frame_offset = offset_reg;
    assign result.payload      = payload_reg;
    assign result.frame_last   = last_reg;
    assign result.frame_number = fnum_reg;

    assign idx      = pos - POS_PAYLOAD;
    assign last_cnt = (last_words_reg > PAYLOAD_WORDS) ? PAYLOAD_WORDS : last_words_reg;

    pfr_hdr_check u_hdr_check (
        .flags           (stream.data_word),
        .header_frame    (hdr_frame_reg),
        .header_packet   (hdr_packet_reg),
        .pkt_big         (pkt_big_reg),
        .pkt_prod        (pkt_prod_reg),
        .current_frame   (cur_frame_reg),
        .expected_packet (exp_packet_reg),
        .frame_ok        (frame_ok_reg),
        .sequence_ok     (seq_ok_reg),
        .frame_words     (frame_words_reg),
        .last_words      (last_words_reg),
        .dec             (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= FRAME_WORDS_RST;
            last_words_reg  <= LAST_WORDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WORDS: frame_words_reg <= cfg_data;
                REG_LAST_WORDS:  last_words_reg  <= cfg_data[LAST_WORDS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        word_pos_next   = word_pos_reg;
        cur_frame_next  = cur_frame_reg;
        exp_packet_next = exp_packet_reg;
        frame_ok_next   = frame_ok_reg;
        seq_ok_next     = seq_ok_reg;
        skip_next       = skip_reg;
        stopped_next    = stopped_reg;
        copy_next       = copy_reg;
        hdr_frame_next  = hdr_frame_reg;
        hdr_packet_next = hdr_packet_reg;
        pkt_big_next    = pkt_big_reg;
        pkt_prod_next   = pkt_prod_reg;
        base_next       = base_reg;

        out_valid_next  = out_valid_reg && !result.ready;
        kind_next       = kind_reg;
        offset_next     = offset_reg;
        payload_next    = payload_reg;
        last_next       = last_reg;
        fnum_next       = fnum_reg;

        pos      = stream.batch_first ? '0 : word_pos_reg;
        skip_eff = stream.batch_first ? 1'b0 : skip_reg;
        copy_eff = stream.batch_first ? COPY_NONE : copy_reg;

        if (accept)
        begin
            out_valid_next = 1'b0;
            kind_next      = KIND_PAYLOAD;
            offset_next    = '0;
            payload_next   = '0;
            last_next      = 1'b0;
            fnum_next      = cur_frame_reg;
        end

        if (accept && !stopped_reg)
        begin
            word_pos_next = pos + 7'd1;
            skip_next     = skip_eff;
            copy_next     = copy_eff;
            if (!skip_eff)
            begin
                if (pos == '0)
                begin
                    copy_next = COPY_NONE;
                end
                case (pos)
                    POS_FRAME:
                    begin
                        hdr_frame_next = stream.data_word;
                    end
                    POS_PACKET:
                    begin
                        hdr_packet_next = stream.data_word;
                        pkt_big_next    = |stream.data_word[DATA_W-1:FRAME_WORDS_W];
                        pkt_prod_next   = PROD_W'(stream.data_word[FRAME_WORDS_W-1:0])
                                          * PROD_W'(PAYLOAD_WORDS);
                        base_next       = OFFSET_W'(stream.data_word[OFFSET_W-1:0] - 16'd1)
                                          * OFFSET_W'(PAYLOAD_WORDS);
                    end
                    POS_FLAGS:
                    begin
                        cur_frame_next  = dec.cur_frame;
                        exp_packet_next = dec.exp_packet;
                        frame_ok_next   = dec.frame_ok;
                        seq_ok_next     = dec.seq_ok;
                        skip_next       = dec.skip;
                        stopped_next    = dec.stop;
                        copy_next       = dec.copy;
                        out_valid_next  = dec.emit;
                        kind_next       = dec.kind;
                        fnum_next       = dec.cur_frame;
                    end
                    default:
                    begin
                        if ((pos inside {[POS_PAYLOAD:POS_PAYLOAD_END]})
                            && copy_eff != COPY_NONE)
                        begin
                            offset_next  = base_reg + OFFSET_W'(idx);
                            payload_next = stream.data_word;
                            if (copy_eff == COPY_FULL)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else if (idx < last_cnt)
                            begin
                                out_valid_next = 1'b1;
                                last_next      = ({1'b0, idx} + 8'd1) == {1'b0, last_cnt};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg   <= '0;
            cur_frame_reg  <= 32'd1;
            exp_packet_reg <= 32'd1;
            frame_ok_reg   <= 1'b1;
            seq_ok_reg     <= 1'b1;
            skip_reg       <= 1'b0;
            stopped_reg    <= 1'b0;
            copy_reg       <= COPY_NONE;
            hdr_frame_reg  <= '0;
            hdr_packet_reg <= '0;
            pkt_big_reg    <= 1'b0;
            pkt_prod_reg   <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            word_pos_reg   <= word_pos_next;
            cur_frame_reg  <= cur_frame_next;
            exp_packet_reg <= exp_packet_next;
            frame_ok_reg   <= frame_ok_next;
            seq_ok_reg     <= seq_ok_next;
            skip_reg       <= skip_next;
            stopped_reg    <= stopped_next;
            copy_reg       <= copy_next;
            hdr_frame_reg  <= hdr_frame_next;
            hdr_packet_reg <= hdr_packet_next;
            pkt_big_reg    <= pkt_big_next;
            pkt_prod_reg   <= pkt_prod_next;
            base_reg       <= base_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        offset_reg  <= offset_next;
        payload_reg <= payload_next;
        last_reg    <= last_next;
        fnum_reg    <= fnum_next;
    end

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop state released without reset");

    a_no_result_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced after end of data");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == KIND_PAYLOAD && copy_reg == COPY_LAST))
        else $error("frame end marked outside a last packet copy");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_PAYLOAD) |-> (payload_reg == '0 && offset_reg == '0))
        else $error("status word carries payload data");

endmodule

`default_nettype wire

FILE: sv/pfr_hdr_check.sv
// Header decision at the flags word: end marker, restart, frame, sequence and size checks.
`default_nettype none

module pfr_hdr_check
    import pfr_pkg::*;
(
    input  wire logic [DATA_W-1:0]        flags,
    input  wire logic [DATA_W-1:0]        header_frame,
    input  wire logic [DATA_W-1:0]        header_packet,
    input  wire logic                     pkt_big,
    input  wire logic [PROD_W-1:0]        pkt_prod,
    input  wire logic [DATA_W-1:0]        current_frame,
    input  wire logic [DATA_W-1:0]        expected_packet,
    input  wire logic                     frame_ok,
    input  wire logic                     sequence_ok,
    input  wire logic [FRAME_WORDS_W-1:0] frame_words,
    input  wire logic [LAST_WORDS_W-1:0]  last_words,
    output hdr_dec_t                      dec
);

    logic size_last_bad;
    logic size_full_bad;

    assign size_last_bad = pkt_big
        || ((25'(pkt_prod) + 25'(last_words)) != (25'(frame_words) + 25'(PAYLOAD_WORDS)));
    assign size_full_bad = pkt_big || (pkt_prod > PROD_W'(frame_words));

    always_comb
    begin
        dec            = '0;
        dec.kind       = KIND_PAYLOAD;
        dec.copy       = COPY_NONE;
        dec.cur_frame  = current_frame;
        dec.exp_packet = expected_packet;
        dec.frame_ok   = frame_ok;
        dec.seq_ok     = sequence_ok;
        if (flags == END_MARK)
        begin
            dec.stop = 1'b1;
            dec.emit = 1'b1;
            dec.kind = KIND_END;
        end
        else
        begin
            if (header_packet == 32'd1)
            begin
                dec.exp_packet = 32'd1;
                dec.cur_frame  = header_frame;
                dec.frame_ok   = 1'b1;
                dec.seq_ok     = 1'b1;
            end
            else
            begin
                dec.exp_packet = expected_packet + 32'd1;
            end

            if (dec.cur_frame != header_frame)
            begin
                dec.frame_ok = 1'b0;
                dec.skip     = 1'b1;
                dec.emit     = 1'b1;
                dec.kind     = KIND_FRAME_ERR;
            end
            else if (dec.exp_packet != header_packet)
            begin
                dec.seq_ok = 1'b0;
                dec.skip   = 1'b1;
                dec.emit   = 1'b1;
                dec.kind   = KIND_SEQ_ERR;
            end
            else if (flags[0])
            begin
                if (size_last_bad)
                begin
                    dec.frame_ok = 1'b0;
                    dec.skip     = 1'b1;
                    dec.emit     = 1'b1;
                    dec.kind     = KIND_SIZE_ERR;
                end
                else if (dec.frame_ok && dec.seq_ok)
                begin
                    dec.copy = COPY_LAST;
                end
                else
                begin
                    dec.emit = 1'b1;
                    dec.kind = KIND_LOST;
                end
            end
            else if (size_full_bad)
            begin
                dec.frame_ok = 1'b0;
                dec.skip     = 1'b1;
                dec.emit     = 1'b1;
                dec.kind     = KIND_SIZE_ERR;
            end
            else
            begin
                dec.copy = COPY_FULL;
            end
        end
    end

endmodule

`default_nettype wire

FILE: dv/pfr_result_checker.sv
// Result checker for the packet frame reassembler: predicts each result from accepted words.
module pfr_result_checker
    import pfr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [FRAME_WORDS_W-1:0] cfg_data,
    pfr_in_if                        stream,
    pfr_out_if                       result,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] frame_offset;
        logic [31:0] payload;
        logic        frame_last;
        logic [31:0] frame_number;
    } frame_result_t;

    frame_result_t awaited_results[$];

    logic [FRAME_WORDS_W-1:0] frame_words_q;
    logic [LAST_WORDS_W-1:0]  last_words_q;
    logic [POS_W-1:0]         word_pos;
    logic [DATA_W-1:0]        cur_frame;
    logic [DATA_W-1:0]        exp_packet;
    logic [DATA_W-1:0]        hdr_frame;
    logic [DATA_W-1:0]        hdr_packet;
    logic                     frame_good;
    logic                     seq_good;
    logic                     skipping;
    logic                     halted;
    copy_t                    copy_mode;

    initial mismatches = 0;

    task automatic queue_result(input kind_t k, input logic [15:0] offset,
                                input logic [31:0] value, input logic last);
        frame_result_t r;
        r.kind         = k;
        r.frame_offset = offset;
        r.payload      = value;
        r.frame_last   = last;
        r.frame_number = cur_frame;
        awaited_results.push_back(r);
    endtask

    task automatic judge_header(input logic [31:0] flags);
        logic [63:0] pkt_span;
        logic [63:0] need_span;
        pkt_span  = {32'd0, hdr_packet} * PAYLOAD_WORDS;
        need_span = frame_words_q + PAYLOAD_WORDS;
        copy_mode = COPY_NONE;
        if (flags == END_MARK)
        begin
            halted = 1'b1;
            queue_result(KIND_END, '0, '0, 1'b0);
            return;
        end
        if (hdr_packet == 32'd1)
        begin
            exp_packet = 32'd1;
            cur_frame  = hdr_frame;
            frame_good = 1'b1;
            seq_good   = 1'b1;
        end
        else
        begin
            exp_packet = exp_packet + 32'd1;
        end
        if (cur_frame != hdr_frame)
        begin
            frame_good = 1'b0;
            skipping   = 1'b1;
            queue_result(KIND_FRAME_ERR, '0, '0, 1'b0);
        end
        else if (exp_packet != hdr_packet)
        begin
            seq_good = 1'b0;
            skipping = 1'b1;
            queue_result(KIND_SEQ_ERR, '0, '0, 1'b0);
        end
        else if (flags[0])
        begin
            if (pkt_span + last_words_q != need_span)
            begin
                frame_good = 1'b0;
                skipping   = 1'b1;
                queue_result(KIND_SIZE_ERR, '0, '0, 1'b0);
            end
            else if (frame_good && seq_good)
            begin
                copy_mode = COPY_LAST;
            end
            else
            begin
                queue_result(KIND_LOST, '0, '0, 1'b0);
            end
        end
        else if (pkt_span > frame_words_q)
        begin
            frame_good = 1'b0;
            skipping   = 1'b1;
            queue_result(KIND_SIZE_ERR, '0, '0, 1'b0);
        end
        else
        begin
            copy_mode = COPY_FULL;
        end
    endtask

    task automatic reassemble_word(input logic [31:0] w, input logic first);
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        idx;
        logic [LAST_WORDS_W-1:0] cnt;
        logic [63:0]             offset;
        if (halted)
            return;
        if (first)
        begin
            word_pos  = '0;
            skipping  = 1'b0;
            copy_mode = COPY_NONE;
        end
        pos      = word_pos;
        word_pos = pos + 7'd1;
        if (skipping)
            return;
        if (pos == '0)
            copy_mode = COPY_NONE;
        if (pos == POS_FRAME)
        begin
            hdr_frame = w;
        end
        else if (pos == POS_PACKET)
        begin
            hdr_packet = w;
        end
        else if (pos == POS_FLAGS)
        begin
            judge_header(w);
        end
        else if (pos >= POS_PAYLOAD && pos <= POS_PAYLOAD_END && copy_mode != COPY_NONE)
        begin
            idx    = pos - POS_PAYLOAD;
            offset = ({32'd0, hdr_packet} - 64'd1) * PAYLOAD_WORDS + idx;
            cnt    = (last_words_q > PAYLOAD_WORDS) ? PAYLOAD_WORDS : last_words_q;
            if (copy_mode == COPY_FULL)
                queue_result(KIND_PAYLOAD, offset[15:0], w, 1'b0);
            else if (idx < cnt)
                queue_result(KIND_PAYLOAD, offset[15:0], w, (idx + 7'd1) == cnt);
        end
    endtask

    task automatic report_mismatch(input string what, input frame_result_t want,
                                   input frame_result_t got);
        if (mismatches < 10)
            $display("%0t %s: expected kind %0d offset %0d payload %h last %0b frame %h;",
                     $realtime, what, want.kind, want.frame_offset, want.payload,
                     want.frame_last, want.frame_number,
                     " got kind %0d offset %0d payload %h last %0b frame %h",
                     got.kind, got.frame_offset, got.payload, got.frame_last,
                     got.frame_number);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            frame_words_q = FRAME_WORDS_RST;
            last_words_q  = LAST_WORDS_RST;
            word_pos      = '0;
            cur_frame     = 32'd1;
            exp_packet    = 32'd1;
            hdr_frame     = '0;
            hdr_packet    = '0;
            frame_good    = 1'b1;
            seq_good      = 1'b1;
            skipping      = 1'b0;
            halted        = 1'b0;
            copy_mode     = COPY_NONE;
            awaited_results.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.kind         = kind_t'(result.kind);
                got.frame_offset = result.frame_offset;
                got.payload      = result.payload;
                got.frame_last   = result.frame_last;
                got.frame_number = result.frame_number;
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with none awaited", '0, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want !== got)
                        report_mismatch("result differs", want, got);
                end
            end
            if (stream.valid && stream.ready)
                reassemble_word(stream.data_word, stream.batch_first);
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WORDS)
                    frame_words_q = cfg_data;
                else if (cfg_index == REG_LAST_WORDS)
                    last_words_q = cfg_data[LAST_WORDS_W-1:0];
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: dv/tb_packet_frame_reassembler_top.sv
// Testbench top for the packet frame reassembler: stimulus, configuration phases and verdict.
module tb_packet_frame_reassembler_top;
    import pfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [FRAME_WORDS_W-1:0] cfg_data;
    int                       mismatches;
    int                       outstanding;
    int                       send_idle_pct;
    int                       stall_pct;
    int                       words_sent;
    bit                       new_batch = 1'b1;

    int idle_table  [4] = '{0, 50, 0, 17};
    int stall_table [4] = '{0, 0, 50, 17};
    logic [FRAME_WORDS_W-1:0] fw_table  [7] =
        '{17'd1, 17'd240, 17'd65536, 17'd120, 17'd247, 17'd0, 17'd200};
    logic [FRAME_WORDS_W-1:0] lpw_table [7] =
        '{17'd1, 17'd120, 17'd16, 17'd0, 17'd127, 17'd0, 17'd80};

    pfr_in_if  stream_ch ();
    pfr_out_if result_ch ();

    packet_frame_reassembler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    pfr_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stream      (stream_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("packet_frame_reassembler_top: mismatch");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w, input bit first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stream_ch.valid <= 1'b0;
            @(posedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.data_word   <= w;
        stream_ch.batch_first <= first;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_packet(input logic [31:0] frm, input logic [31:0] idx,
                               input logic [31:0] flags, input bit first, input int len);
        logic [31:0] w;
        for (int i = 0; i < len; i++)
        begin
            if (i == POS_FRAME)
                w = frm;
            else if (i == POS_PACKET)
                w = idx;
            else if (i == POS_FLAGS)
                w = flags;
            else
                w = $urandom();
            send_word(w, first && i == 0);
        end
    endtask

    task automatic send_frame(input logic [FRAME_WORDS_W-1:0] fw,
                              input logic [FRAME_WORDS_W-1:0] lpw);
        int          n;
        int          count;
        int          len;
        bit          spoilt;
        logic [31:0] frm;
        logic [31:0] frm_k;
        logic [31:0] idx;
        logic [31:0] flags;
        if (fw >= lpw && (fw - lpw) % 120 == 0)
            n = (fw - lpw) / 120 + 1;
        else
            n = $urandom_range(1, 3);
        // abandon long frames after a few packets
        count = (n > 3) ? $urandom_range(1, 3) : n;
        frm   = pick_word();
        for (int k = 1; k <= count; k++)
        begin
            frm_k    = frm;
            idx      = k;
            len      = 128;
            spoilt   = 1'b0;
            flags    = $urandom();
            flags[0] = (k == n);
            if ($urandom_range(99) < 25)
            begin
                spoilt = 1'b1;
                case ($urandom_range(3))
                    0:       frm_k = frm ^ ($urandom() | 32'd1);
                    1:       idx = $urandom_range(1) ? k + $urandom_range(1, 3) : $urandom();
                    2:       flags[0] = ~flags[0];
                    default: len = $urandom_range(1, 127);
                endcase
            end
            if (flags == END_MARK)
                flags[31] = 1'b1;
            send_packet(frm_k, idx, flags, new_batch, len);
            if (len < 128)
                new_batch = 1'b1;
            else if (spoilt)
                new_batch = ($urandom_range(3) != 0);
            else
                new_batch = ($urandom_range(7) == 0);
        end
    endtask

    task automatic apply_setting(input logic [FRAME_WORDS_W-1:0] fw,
                                 input logic [FRAME_WORDS_W-1:0] lpw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WORDS;
        cfg_data  <= fw;
        @(posedge clk);
        cfg_index <= REG_LAST_WORDS;
        cfg_data  <= lpw;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int start;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_FRAME_WORDS;
        cfg_data              = '0;
        stream_ch.valid       = 1'b0;
        stream_ch.data_word   = '0;
        stream_ch.batch_first = 1'b0;
        send_idle_pct         = 17;
        stall_pct             = 17;
        words_sent            = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // broken sequence, lost frame, frame break, size break on a last packet
        apply_setting(17'd360, 17'd120);
        send_packet(32'd1, 32'd5, 32'd0, 1'b1, 6);
        send_packet(32'd1, 32'd3, 32'd1, 1'b1, 6);
        send_packet(32'd7, 32'd4, 32'd0, 1'b1, 6);
        send_packet(32'd1, 32'd5, 32'hFFFF_FFFF, 1'b1, 6);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            apply_setting(fw_table[ph], lpw_table[ph]);
            send_idle_pct = idle_table[ph % 4];
            stall_pct     = stall_table[ph % 4];
            new_batch     = 1'b1;
            start         = words_sent;
            while (words_sent - start < 150)
                send_frame(fw_table[ph], lpw_table[ph]);
        end

        wait_idle();
        send_packet($urandom(), 32'd1, END_MARK, 1'b1, 16);
        wait_idle();
        if (mismatches == 0)
            $display("packet_frame_reassembler_top: match");
        else
            $display("packet_frame_reassembler_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
sv/pfr_pkg.sv
sv/pfr_in_if.sv
sv/pfr_out_if.sv
sv/pfr_hdr_check.sv
sv/packet_frame_reassembler_top.sv
dv/pfr_result_checker.sv
dv/tb_packet_frame_reassembler_top.sv
